[design/ddof_pkg.sv]
package ddof_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CW    = 35;
	localparam int ACC_W = 64;
	localparam int MB_W  = 35;
	localparam int DIV_W = 52;
	localparam int REM_W = 32;
	localparam int HW    = 20;

	localparam logic signed [CW-1:0]    GAIN_Q30    = 35'sd652032874;
	localparam logic signed [HW-1:0]    HEAD_PI     = 20'sd25736;
	localparam logic signed [HW-1:0]    HEAD_TWO_PI = 20'sd51472;
	localparam logic [20:0]             TIMER_MAX   = 21'd2097151;
	localparam logic signed [ACC_W-1:0] Q60_HALF    = 64'sh0000_2000_0000_0000;
	localparam logic signed [ACC_W-1:0] POS_HALF    = 64'sd1024000000;
	localparam logic signed [ACC_W-1:0] HEAD_HALF   = 64'sd500000;
	localparam logic [REM_W-1:0]        POS_DEN     = 32'd2048000000;
	localparam logic [REM_W-1:0]        HEAD_DEN    = 32'd1000000;

	localparam logic [11:0] SEP_RST    = 12'd420;
	localparam logic [13:0] THR_RST    = 14'd41;
	localparam logic [16:0] GYRO_W_RST = 17'd64225;
	localparam logic [19:0] MAX_DT_RST = 20'd500000;
	localparam logic [19:0] PERIOD_RST = 20'd20000;

	typedef enum logic [2:0] {
		REG_WHEEL_SEP  = 3'd0,
		REG_STAT_THR   = 3'd1,
		REG_GYRO_W     = 3'd2,
		REG_MAX_DT     = 3'd3,
		REG_PUB_PERIOD = 3'd4
	} ddof_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_ENC_DIV, ST_MUL_G, ST_MUL_E, ST_CORD_P,
		ST_MUL_CC, ST_MUL_SS, ST_MUL_CS, ST_MUL_XD, ST_MUL_XS, ST_DIV_X,
		ST_MUL_YD, ST_MUL_YS, ST_DIV_Y, ST_MUL_H, ST_DIV_H, ST_WRAP,
		ST_TIMER, ST_CORD_O, ST_OUT
	} ddof_state_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0: r = 30'd843314856;
			5'd1: r = 30'd497837829;
			5'd2: r = 30'd263043836;
			5'd3: r = 30'd133525158;
			5'd4: r = 30'd67021686;
			5'd5: r = 30'd33543515;
			5'd6: r = 30'd16775850;
			5'd7: r = 30'd8388437;
			5'd8: r = 30'd4194282;
			5'd9: r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] q60_to_q14(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		logic signed [15:0] r;
		t = (v + Q60_HALF) >>> 46;
		if (t > 64'sd16384) r = 16'sd16384;
		else if (t < -64'sd16384) r = -16'sd16384;
		else r = 16'(t);
		return r;
	endfunction

	function automatic logic signed [15:0] q30_to_q14(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		logic signed [15:0] r;
		t = (v + 35'sd32768) >>> 16;
		if (t > 35'sd16384) r = 16'sd16384;
		else if (t < -35'sd16384) r = -16'sd16384;
		else r = 16'(t);
		return r;
	endfunction

	function automatic logic signed [15:0] rate_round(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		logic signed [15:0] r;
		t = (v + 64'sd32768) >>> 16;
		if (t > 64'sd32767) r = 16'sh7FFF;
		else if (t < -64'sd32768) r = 16'sh8000;
		else r = 16'(t);
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (v < -34'sd2147483648) r = 32'sh8000_0000;
		else r = 32'(v);
		return r;
	endfunction

endpackage

[design/ddof_if.sv]
interface ddof_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_speed;
	logic signed [15:0] right_speed;
	logic signed [15:0] gyro_yaw_rate;
	logic [19:0]        elapsed_us;

	modport source (output valid, left_speed, right_speed, gyro_yaw_rate, elapsed_us,
		input ready);
	modport sink (input valid, left_speed, right_speed, gyro_yaw_rate, elapsed_us,
		output ready);
endinterface

interface ddof_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] heading_angle;
	logic signed [15:0] orient_z;
	logic signed [15:0] orient_w;
	logic signed [15:0] linear_speed;
	logic signed [15:0] turn_rate;

	modport source (output valid, pos_x, pos_y, heading_angle, orient_z, orient_w,
		linear_speed, turn_rate, input ready);
	modport sink (input valid, pos_x, pos_y, heading_angle, orient_z, orient_w,
		linear_speed, turn_rate, output ready);
endinterface

interface ddof_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [19:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/diff_drive_odometry_fusion.sv]
// Differential-drive odometry with gyro/encoder turn-rate blend.
// sample (sink): one word per sensor packet - wheel speeds, gyro rate, elapsed us.
// pose (source): pose, yaw quaternion, speed and turn rate, emitted when the
//   publish period has gathered; at most one pose word per sample word.
// cfg (sink): register writes, always ready, to be issued while idle.
// One sample at a time: sample.ready is high only when idle. A rejected word
// (elapsed zero or over limit) returns to idle from the check state; the work
// on an accepted word is set by four 52-step bit-serial divides (three for a
// stationary word), the shift-add products (one multiplier bit a cycle) and
// one or two CORDIC passes.
// Results sit in an output register: a stalled receiver does not block the
// next sample; only a new pose word waits for the register to empty.
// Reset clears pose, heading, publish timer and loads register defaults;
// sample.ready is high during and after reset, since the state resets to idle.
module diff_drive_odometry_fusion #(
	parameter int CORDIC_STEPS = ddof_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ddof_in_if.sink     sample,
	ddof_out_if.source  pose,
	ddof_cfg_if.sink    cfg
);
	import ddof_pkg::*;

	localparam int CI_W = $clog2(CORDIC_STEPS + 1);
	localparam int DCW  = $clog2(DIV_W + 1);

	ddof_state_t state_q, state_d;

	logic [11:0] sep_q;
	logic [13:0] thr_q;
	logic [16:0] gw_q;
	logic [19:0] maxdt_q, period_q;

	logic signed [15:0] left_q, right_q, gyro_q;
	logic [19:0]        dt_q;
	logic signed [15:0] speed_q, rate_q, co_q, so_q, head_q;
	logic signed [26:0] enc_q;
	logic signed [31:0] x_q, y_q;
	logic [20:0]        tsp_q;
	logic signed [HW-1:0] hw_q;

	logic signed [ACC_W-1:0] acc_q, mac_a_q;
	logic [MB_W-1:0]         mac_b_q;

	logic [DIV_W-1:0] div_n_q;
	logic [REM_W-1:0] div_r_q, div_d_q;
	logic             div_neg_q;
	logic [DCW-1:0]   div_cnt_q;

	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [CI_W-1:0]      ci_q;

	logic               out_valid_q;
	logic signed [31:0] ox_q, oy_q;
	logic signed [15:0] oh_q, oz_q, ow_q, osp_q, ort_q;

	logic in_ready, mac_run, div_run, cord_run;
	logic mac_done, div_done, cord_done, out_free;

	logic signed [16:0] l_ext, r_ext, sum17, diff17;
	logic [16:0]        l_abs, r_abs;
	logic               stationary, dt_bad;
	logic signed [26:0] enc_num;
	logic [11:0]        sep_eff;
	logic [16:0]        w_eff, w_cmp;
	logic [CW-1:0]      c_abs, s_abs;
	logic signed [CW-1:0] cs_a;
	logic [15:0]        spd_abs;

	logic signed [ACC_W-1:0] div_src, div_mag, div_quo, q_floor, q_trunc;
	logic [REM_W-1:0]        div_den, rem_nx;
	logic [REM_W:0]          rem_sh;
	logic                    rem_ge;

	logic signed [CW-1:0] dx, dy, at;
	logic signed [33:0]   nx34, ny34;
	logic signed [HW-1:0] hw_new;
	logic [21:0]          t22;
	logic [20:0]          t_sat;
	logic                 pub;

	assign mac_done  = (mac_b_q == '0);
	assign div_done  = (div_cnt_q == '0);
	assign cord_done = (ci_q == CI_W'(CORDIC_STEPS));
	assign out_free  = !out_valid_q || pose.ready;

	always_comb begin
		l_ext      = 17'(left_q);
		r_ext      = 17'(right_q);
		sum17      = l_ext + r_ext;
		diff17     = r_ext - l_ext;
		l_abs      = 17'(l_ext[16] ? -l_ext : l_ext);
		r_abs      = 17'(r_ext[16] ? -r_ext : r_ext);
		stationary = (l_abs < 17'(thr_q)) && (r_abs < 17'(thr_q));
		dt_bad     = (dt_q == '0) || (dt_q > maxdt_q);
		enc_num    = 27'(diff17) * 27'sd500;
		sep_eff    = (sep_q == '0) ? 12'd1 : sep_q;
		w_eff      = (gw_q > 17'd65536) ? 17'd65536 : gw_q;
		w_cmp      = 17'd65536 - w_eff;
		c_abs      = cx_q[CW-1] ? CW'(-cx_q) : CW'(cx_q);
		s_abs      = cy_q[CW-1] ? CW'(-cy_q) : CW'(cy_q);
		cs_a       = cy_q[CW-1] ? -cx_q : cx_q;
		spd_abs    = speed_q[15] ? 16'(-speed_q) : 16'(speed_q);
	end

	always_comb begin
		case (state_q)
			ST_CHECK: begin
				div_src = 64'(enc_num);
				div_den = 32'(sep_eff);
			end
			ST_MUL_XS, ST_MUL_YS: begin
				div_src = acc_q + POS_HALF;
				div_den = POS_DEN;
			end
			ST_MUL_H: begin
				div_src = (acc_q <<< 1) + HEAD_HALF;
				div_den = HEAD_DEN;
			end
			default: begin
				div_src = acc_q;
				div_den = 32'(sep_eff);
			end
		endcase
		div_mag = div_src[ACC_W-1] ? -div_src : div_src;
		rem_sh  = {div_r_q, div_n_q[DIV_W-1]};
		rem_ge  = rem_sh >= {1'b0, div_d_q};
		rem_nx  = rem_ge ? REM_W'(rem_sh - {1'b0, div_d_q}) : REM_W'(rem_sh);
		div_quo = ACC_W'(div_n_q);
		q_trunc = div_neg_q ? -div_quo : div_quo;
		q_floor = div_neg_q ? -(div_quo + ACC_W'(div_r_q != '0)) : div_quo;
	end

	always_comb begin
		dx     = cy_q >>> ci_q;
		dy     = cx_q >>> ci_q;
		at     = CW'(atan_q30(5'(ci_q)));
		nx34   = 34'(x_q) + 34'(q_floor);
		ny34   = 34'(y_q) + 34'(q_floor);
		hw_new = HW'(head_q) + HW'(q_floor);
		t22    = 22'(tsp_q) + 22'(dt_q);
		t_sat  = (t22 > 22'(TIMER_MAX)) ? TIMER_MAX : t22[20:0];
		pub    = t_sat >= 21'(period_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (sample.valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (dt_bad) state_d = ST_IDLE;
				else if (stationary) state_d = ST_CORD_P;
				else state_d = ST_ENC_DIV;
			end
			ST_ENC_DIV: if (div_done) state_d = ST_MUL_G;
			ST_MUL_G:   if (mac_done) state_d = ST_MUL_E;
			ST_MUL_E:   if (mac_done) state_d = ST_CORD_P;
			ST_CORD_P:  if (cord_done) state_d = ST_MUL_CC;
			ST_MUL_CC:  if (mac_done) state_d = ST_MUL_SS;
			ST_MUL_SS:  if (mac_done) state_d = ST_MUL_CS;
			ST_MUL_CS:  if (mac_done) state_d = ST_MUL_XD;
			ST_MUL_XD:  if (mac_done) state_d = ST_MUL_XS;
			ST_MUL_XS:  if (mac_done) state_d = ST_DIV_X;
			ST_DIV_X:   if (div_done) state_d = ST_MUL_YD;
			ST_MUL_YD:  if (mac_done) state_d = ST_MUL_YS;
			ST_MUL_YS:  if (mac_done) state_d = ST_DIV_Y;
			ST_DIV_Y:   if (div_done) state_d = ST_MUL_H;
			ST_MUL_H:   if (mac_done) state_d = ST_DIV_H;
			ST_DIV_H:   if (div_done) state_d = ST_WRAP;
			ST_WRAP: begin
				if (hw_q <= HEAD_PI && hw_q >= -HEAD_PI) state_d = ST_TIMER;
			end
			ST_TIMER:   state_d = pub ? ST_CORD_O : ST_IDLE;
			ST_CORD_O:  if (cord_done) state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		mac_run  = 1'b0;
		div_run  = 1'b0;
		cord_run = 1'b0;
		unique case (state_q)
			ST_MUL_G, ST_MUL_E, ST_MUL_CC, ST_MUL_SS, ST_MUL_CS, ST_MUL_XD,
			ST_MUL_XS, ST_MUL_YD, ST_MUL_YS, ST_MUL_H: mac_run = !mac_done;
			ST_ENC_DIV, ST_DIV_X, ST_DIV_Y, ST_DIV_H: div_run = !div_done;
			ST_CORD_P, ST_CORD_O: cord_run = !cord_done;
			default: ;
		endcase
	end

	assign sample.ready       = in_ready;
	assign cfg.ready          = 1'b1;
	assign pose.valid         = out_valid_q;
	assign pose.pos_x         = ox_q;
	assign pose.pos_y         = oy_q;
	assign pose.heading_angle = oh_q;
	assign pose.orient_z      = oz_q;
	assign pose.orient_w      = ow_q;
	assign pose.linear_speed  = osp_q;
	assign pose.turn_rate     = ort_q;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sep_q       <= SEP_RST;
			thr_q       <= THR_RST;
			gw_q        <= GYRO_W_RST;
			maxdt_q     <= MAX_DT_RST;
			period_q    <= PERIOD_RST;
			x_q         <= '0;
			y_q         <= '0;
			head_q      <= '0;
			tsp_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_WHEEL_SEP:  sep_q    <= cfg.data[11:0];
					REG_STAT_THR:   thr_q    <= cfg.data[13:0];
					REG_GYRO_W:     gw_q     <= {1'b0, cfg.data[15:0]} |
						(cfg.data[16] ? 17'h10000 : 17'h0);
					REG_MAX_DT:     maxdt_q  <= cfg.data;
					REG_PUB_PERIOD: period_q <= cfg.data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && pose.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_DIV_X: if (div_done) x_q <= sat32(nx34);
				ST_DIV_Y: if (div_done) y_q <= sat32(ny34);
				ST_WRAP: begin
					if (hw_q <= HEAD_PI && hw_q >= -HEAD_PI) head_q <= 16'(hw_q);
				end
				ST_TIMER: tsp_q <= pub ? '0 : t_sat;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (mac_run) begin
			acc_q   <= mac_b_q[0] ? acc_q + mac_a_q : acc_q;
			mac_a_q <= mac_a_q <<< 1;
			mac_b_q <= mac_b_q >> 1;
		end
		if (div_run) begin
			div_r_q   <= rem_nx;
			div_n_q   <= {div_n_q[DIV_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q - 1'b1;
		end
		if (cord_run) begin
			if (!cz_q[CW-1]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + at;
			end
			ci_q <= ci_q + 1'b1;
		end

		case (state_q)
			ST_IDLE: begin
				left_q  <= sample.left_speed;
				right_q <= sample.right_speed;
				gyro_q  <= sample.gyro_yaw_rate;
				dt_q    <= sample.elapsed_us;
			end
			ST_CHECK: begin
				if (stationary) begin
					speed_q <= '0;
					rate_q  <= '0;
					cx_q    <= GAIN_Q30;
					cy_q    <= '0;
					cz_q    <= CW'(head_q) <<< 16;
					ci_q    <= '0;
				end else begin
					speed_q   <= sum17[16:1];
					div_neg_q <= div_src[ACC_W-1];
					div_n_q   <= div_mag[DIV_W-1:0];
					div_r_q   <= '0;
					div_d_q   <= div_den;
					div_cnt_q <= DCW'(DIV_W);
				end
			end
			ST_ENC_DIV: begin
				if (div_done) begin
					enc_q   <= 27'(q_trunc);
					acc_q   <= '0;
					mac_a_q <= ACC_W'(gyro_q);
					mac_b_q <= MB_W'(w_eff);
				end
			end
			ST_MUL_G: begin
				if (mac_done) begin
					mac_a_q <= ACC_W'(enc_q);
					mac_b_q <= MB_W'(w_cmp);
				end
			end
			ST_MUL_E: begin
				if (mac_done) begin
					rate_q <= rate_round(acc_q);
					cx_q   <= GAIN_Q30;
					cy_q   <= '0;
					cz_q   <= CW'(head_q) <<< 16;
					ci_q   <= '0;
				end
			end
			ST_CORD_P: begin
				if (cord_done) begin
					acc_q   <= '0;
					mac_a_q <= ACC_W'(c_abs);
					mac_b_q <= MB_W'(c_abs);
				end
			end
			ST_MUL_CC: begin
				if (mac_done) begin
					mac_a_q <= -ACC_W'(s_abs);
					mac_b_q <= MB_W'(s_abs);
				end
			end
			ST_MUL_SS: begin
				if (mac_done) begin
					co_q    <= q60_to_q14(acc_q);
					acc_q   <= '0;
					mac_a_q <= ACC_W'(cs_a);
					mac_b_q <= MB_W'(s_abs);
				end
			end
			ST_MUL_CS: begin
				if (mac_done) begin
					so_q    <= q60_to_q14(acc_q <<< 1);
					acc_q   <= '0;
					mac_a_q <= ACC_W'(co_q);
					mac_b_q <= MB_W'(dt_q);
				end
			end
			ST_MUL_XD, ST_MUL_YD: begin
				if (mac_done) begin
					acc_q   <= '0;
					mac_a_q <= speed_q[15] ? -acc_q : acc_q;
					mac_b_q <= MB_W'(spd_abs);
				end
			end
			ST_MUL_XS, ST_MUL_YS, ST_MUL_H: begin
				if (mac_done) begin
					div_neg_q <= div_src[ACC_W-1];
					div_n_q   <= div_mag[DIV_W-1:0];
					div_r_q   <= '0;
					div_d_q   <= div_den;
					div_cnt_q <= DCW'(DIV_W);
				end
			end
			ST_DIV_X: begin
				if (div_done) begin
					acc_q   <= '0;
					mac_a_q <= ACC_W'(so_q);
					mac_b_q <= MB_W'(dt_q);
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					acc_q   <= '0;
					mac_a_q <= ACC_W'(rate_q);
					mac_b_q <= MB_W'(dt_q);
				end
			end
			ST_DIV_H: if (div_done) hw_q <= hw_new;
			ST_WRAP: begin
				if (hw_q > HEAD_PI) hw_q <= hw_q - HEAD_TWO_PI;
				else if (hw_q < -HEAD_PI) hw_q <= hw_q + HEAD_TWO_PI;
			end
			ST_TIMER: begin
				cx_q <= GAIN_Q30;
				cy_q <= '0;
				cz_q <= CW'(head_q) <<< 16;
				ci_q <= '0;
			end
			ST_OUT: begin
				if (out_free) begin
					ox_q  <= x_q;
					oy_q  <= y_q;
					oh_q  <= head_q;
					oz_q  <= q30_to_q14(cy_q);
					ow_q  <= q30_to_q14(cx_q);
					osp_q <= speed_q;
					ort_q <= rate_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[design/ddof_checker.sv]
module ddof_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               s_valid,
	input logic               s_ready,
	input logic               p_valid,
	input logic               p_ready,
	input logic signed [31:0] p_pos_x,
	input logic signed [15:0] p_heading
);

	// a stalled pose word holds
	a_pose_hold: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && !p_ready |=> p_valid && $stable(p_pos_x) && $stable(p_heading))
		else $error("pose word changed while stalled");

	// one sample at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("sample taken while busy");

	// a new pose word comes out of sample processing, never while idle
	a_pose_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(p_valid) |-> $past(!s_ready))
		else $error("pose word without a sample in progress");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !p_valid)
		else $error("pose word during reset");

endmodule

bind diff_drive_odometry_fusion ddof_checker u_ddof_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_valid   (sample.valid),
	.s_ready   (sample.ready),
	.p_valid   (pose.valid),
	.p_ready   (pose.ready),
	.p_pos_x   (pose.pos_x),
	.p_heading (pose.heading_angle)
);

[test/diff_drive_odometry_fusion_tb.sv]
module diff_drive_odometry_fusion_tb;
	import ddof_pkg::*;

	typedef struct packed {
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic signed [15:0] gyro_yaw_rate;
		logic [19:0]        elapsed_us;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading_angle;
		logic signed [15:0] orient_z;
		logic signed [15:0] orient_w;
		logic signed [15:0] linear_speed;
		logic signed [15:0] turn_rate;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ddof_in_if  sample();
	ddof_out_if pose();
	ddof_cfg_if cfg();

	diff_drive_odometry_fusion i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.pose   (pose.source),
		.cfg    (cfg.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [11:0] m_sep;
	logic [13:0] m_thr;
	logic [16:0] m_gw;
	logic [19:0] m_max_dt;
	logic [19:0] m_period;
	longint      m_x, m_y, m_head, m_timer;

	sample_t pending_samples[$];
	pose_t   expected_poses[$];
	int      errors = 0;
	bit      calm = 1'b0;
	bit      cfg_done;

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic rotate_half(input longint hd, output longint c, output longint s);
		longint x, y, z, dx, dy, a;
		x = 652032874;
		y = 0;
		z = hd * 65536;
		for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
			dx = floor_div(y, longint'(1) << i);
			dy = floor_div(x, longint'(1) << i);
			a = longint'(atan_q30(5'(i)));
			if (z >= 0) begin
				x -= dx; y += dy; z -= a;
			end else begin
				x += dx; y -= dy; z += a;
			end
		end
		c = x;
		s = y;
	endtask

	function automatic longint q60_q14(longint v);
		longint h;
		h = longint'(1) << 45;
		return clamp(floor_div(v + h, h * 2), -16384, 16384);
	endfunction

	function automatic longint q30_q14(longint v);
		return clamp(floor_div(v + 32768, 65536), -16384, 16384);
	endfunction

	task automatic predict_odometry(input sample_t it);
		longint l, r, g, dt, spd, rate, sum, sep, w, enc, c, s, co, so, h;
		pose_t p;
		l = it.left_speed;
		r = it.right_speed;
		g = it.gyro_yaw_rate;
		dt = it.elapsed_us;
		spd = 0;
		rate = 0;
		if (dt == 0 || dt > m_max_dt) return;
		if (!((l < 0 ? -l : l) < m_thr && (r < 0 ? -r : r) < m_thr)) begin
			sum = l + r;
			sep = m_sep != 0 ? m_sep : 1;
			w = m_gw > 65536 ? 65536 : m_gw;
			enc = ((r - l) * 500) / sep;
			spd = (sum - (sum & 1)) / 2;
			rate = clamp(floor_div(w * g + (65536 - w) * enc + 32768, 65536), -32768, 32767);
		end
		rotate_half(m_head, c, s);
		co = q60_q14(c * c - s * s);
		so = q60_q14(2 * c * s);
		m_x = clamp(m_x + floor_div(spd * co * dt + 1024000000, 2048000000),
			-64'sd2147483648, 64'sd2147483647);
		m_y = clamp(m_y + floor_div(spd * so * dt + 1024000000, 2048000000),
			-64'sd2147483648, 64'sd2147483647);
		h = m_head + floor_div(rate * dt * 2 + 500000, 1000000);
		while (h > 25736) h -= 51472;
		while (h < -25736) h += 51472;
		m_head = h;
		m_timer = m_timer + dt > 2097151 ? 2097151 : m_timer + dt;
		if (m_timer < m_period) return;
		m_timer = 0;
		rotate_half(m_head, c, s);
		p.pos_x = 32'(m_x);
		p.pos_y = 32'(m_y);
		p.heading_angle = 16'(m_head);
		p.orient_z = 16'(q30_q14(s));
		p.orient_w = 16'(q30_q14(c));
		p.linear_speed = 16'(spd);
		p.turn_rate = 16'(rate);
		expected_poses.push_back(p);
	endtask

	// sample driver
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (sample.valid && sample.ready) begin
				predict_odometry(pending_samples.pop_front());
			end
			if (!(sample.valid && !sample.ready)) begin
				if (in_gap > 0) begin
					in_gap--;
					sample.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					in_gap = $urandom_range(1, 18);
					sample.valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					sample.valid <= 1'b1;
					{sample.left_speed, sample.right_speed, sample.gyro_yaw_rate,
						sample.elapsed_us} <= pending_samples[0];
				end else begin
					sample.valid <= 1'b0;
				end
			end
		end
	end

	// pose monitor
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose.ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (pose.valid && pose.ready) begin
				if (expected_poses.size() == 0) begin
					$error("unexpected pose word");
					errors++;
				end else begin
					pose_t e;
					e = expected_poses.pop_front();
					if (pose.pos_x !== e.pos_x) begin
						$error("pos_x exp %0d got %0d", e.pos_x, pose.pos_x); errors++;
					end
					if (pose.pos_y !== e.pos_y) begin
						$error("pos_y exp %0d got %0d", e.pos_y, pose.pos_y); errors++;
					end
					if (pose.heading_angle !== e.heading_angle) begin
						$error("heading_angle exp %0d got %0d", e.heading_angle,
							pose.heading_angle); errors++;
					end
					if (pose.orient_z !== e.orient_z) begin
						$error("orient_z exp %0d got %0d", e.orient_z, pose.orient_z); errors++;
					end
					if (pose.orient_w !== e.orient_w) begin
						$error("orient_w exp %0d got %0d", e.orient_w, pose.orient_w); errors++;
					end
					if (pose.linear_speed !== e.linear_speed) begin
						$error("linear_speed exp %0d got %0d", e.linear_speed,
							pose.linear_speed); errors++;
					end
					if (pose.turn_rate !== e.turn_rate) begin
						$error("turn_rate exp %0d got %0d", e.turn_rate, pose.turn_rate);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				pose.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(1, 18);
				pose.ready <= 1'b0;
			end else begin
				pose.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input ddof_reg_t idx, input logic [19:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		cfg_done = 1'b0;
		while (!cfg_done) begin
			@(posedge clk);
			if (cfg.valid && cfg.ready) cfg_done = 1'b1;
		end
		cfg.valid <= 1'b0;
		case (idx)
			REG_WHEEL_SEP:  m_sep = val[11:0];
			REG_STAT_THR:   m_thr = val[13:0];
			REG_GYRO_W:     m_gw = val[16:0];
			REG_MAX_DT:     m_max_dt = val;
			REG_PUB_PERIOD: m_period = val;
			default: ;
		endcase
	endtask

	task automatic drain;
		wait (pending_samples.size() == 0 && !sample.valid && expected_poses.size() == 0);
		repeat (700) @(posedge clk);
		wait (expected_poses.size() == 0);
	endtask

	function automatic sample_t rand_sample(int mode);
		sample_t s;
		s.left_speed = 16'($urandom);
		s.right_speed = 16'($urandom);
		s.gyro_yaw_rate = 16'($urandom);
		case (mode)
			0: s.elapsed_us = 20'($urandom);
			1: s.elapsed_us = 20'($urandom_range(1, 60000));
			default: s.elapsed_us = 20'($urandom_range(0, 3));
		endcase
		if ($urandom_range(0, 4) == 0) begin
			s.left_speed = 16'($signed($urandom_range(0, 80)) - 40);
			s.right_speed = 16'($signed($urandom_range(0, 80)) - 40);
		end else if ($urandom_range(0, 3) == 0) begin
			s.left_speed = 16'($signed($urandom_range(0, 4000)) - 2000);
			s.right_speed = s.left_speed + 16'($signed($urandom_range(0, 400)) - 200);
		end
		return s;
	endfunction

	task automatic add(input logic [15:0] l, r, g, input logic [19:0] dt);
		pending_samples.push_back({l, r, g, dt});
	endtask

	initial begin
		sample.valid = 1'b0;
		sample.left_speed = '0;
		sample.right_speed = '0;
		sample.gyro_yaw_rate = '0;
		sample.elapsed_us = '0;
		pose.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_WHEEL_SEP;
		cfg.data = '0;
		m_sep = SEP_RST; m_thr = THR_RST; m_gw = GYRO_W_RST;
		m_max_dt = MAX_DT_RST; m_period = PERIOD_RST;
		m_x = 0; m_y = 0; m_head = 0; m_timer = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings
		add(16'sd1000, 16'sd1000, 16'sd0, 20'd0);
		add(16'sd1000, 16'sd1000, 16'sd0, 20'd500001);
		add(16'sd1000, 16'sd1000, 16'sd0, 20'd500000);
		add(16'sd10, -16'sd10, 16'sd2000, 20'd30000);
		add(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 20'd25000);
		add(16'sh8000, 16'sh8000, 16'sh8000, 20'd25000);
		add(16'sh8000, 16'sh7FFF, 16'sh7FFF, 20'd500000);
		add(16'sh7FFF, 16'sh8000, 16'sh8000, 20'd500000);
		add(16'sd41, -16'sd41, 16'sd0, 20'd20000);
		add(-16'sd3, 16'sd0, 16'sd0, 20'd1);
		drain();

		// extremes of configuration
		write_reg(REG_WHEEL_SEP, 20'd0);
		write_reg(REG_STAT_THR, 20'd0);
		write_reg(REG_GYRO_W, 20'd0);
		write_reg(REG_MAX_DT, 20'hFFFFF);
		write_reg(REG_PUB_PERIOD, 20'd0);
		add(16'sh7FFF, 16'sh8000, 16'sh7FFF, 20'hFFFFF);
		add(16'sh7FFF, 16'sh7FFF, 16'sh0, 20'hFFFFF);
		add(16'sh7FFF, 16'sh7FFF, 16'sh0, 20'hFFFFF);
		add(16'sh7FFF, 16'sh7FFF, 16'sh0, 20'hFFFFF);
		add(16'sh8000, 16'sh8000, 16'sh0, 20'hFFFFF);
		add(16'sd0, 16'sd0, 16'sh7FFF, 20'd1);
		drain();
		write_reg(REG_GYRO_W, 20'h1FFFF);
		write_reg(REG_STAT_THR, 20'h3FFF);
		write_reg(REG_WHEEL_SEP, 20'hFFF);
		write_reg(REG_MAX_DT, 20'd1);
		write_reg(REG_PUB_PERIOD, 20'hFFFFF);
		add(16'sd100, 16'sd200, 16'sd300, 20'd1);
		add(16'sd100, 16'sd200, 16'sd300, 20'd2);
		add(16'sh7FFF, 16'sd0, 16'sd300, 20'd1);
		drain();

		// random phases
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_WHEEL_SEP, 20'($urandom_range(50, 4000)));
			write_reg(REG_STAT_THR, 20'($urandom_range(0, 200)));
			write_reg(REG_GYRO_W, 20'($urandom_range(0, 65536)));
			write_reg(REG_MAX_DT, ph == 0 ? 20'hFFFFF : 20'($urandom_range(30000, 500000)));
			write_reg(REG_PUB_PERIOD, ph == 1 ? 20'd0 : 20'($urandom_range(0, 40000)));
			if (ph == 5) calm = 1'b1;
			for (int k = 0; k < 140; k++) begin
				int pick;
				pick = $urandom_range(0, 19);
				pending_samples.push_back(rand_sample(pick < 3 ? 0 : (pick < 18 ? 1 : 2)));
			end
			drain();
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#25000000;
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
design/ddof_pkg.sv
design/ddof_if.sv
design/diff_drive_odometry_fusion.sv
design/ddof_checker.sv
test/diff_drive_odometry_fusion_tb.sv
